// ----- design/bomp_pkg.sv -----
// shared types and constants for the box overlap minimum push unit
// no dependencies
package bomp_pkg;

    localparam int EXT_W = 34;
    localparam int HALF_W = 32;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input word
        logic hx;       // compute half extents
        logic ext;      // compute corner products
        logic res;      // compute result
    } bomp_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HALF = 5'b00010,
        ST_EXT  = 5'b00100,
        ST_RES  = 5'b01000,
        ST_OUT  = 5'b10000
    } bomp_state_t;

endpackage

// ----- design/bomp_ctrl.sv -----
// controller state machine: sequences capture, half extents, corners, result and output
// depends on bomp_pkg
module bomp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic              out_busy,
    output logic              out_set,
    output bomp_pkg::bomp_cmd_t cmd
);
    import bomp_pkg::*;

    bomp_state_t state_reg, state_next;
    logic mode_reg, mode_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        out_set    = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    mode_next  = mode;
                    state_next = ST_HALF;
                end
            end
            ST_HALF:
            begin
                cmd.hx     = 1'b1;
                state_next = ST_EXT;
            end
            ST_EXT:
            begin
                cmd.ext    = 1'b1;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                cmd.res    = 1'b1;
                state_next = mode_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    out_set    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// ----- design/bomp_datapath.sv -----
// datapath: half extents, corner extents, overlap test and push selection
// depends on bomp_pkg
module bomp_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  bomp_pkg::bomp_cmd_t cmd,
    input  logic [192:0]        in_word,
    output logic                res_colliding,
    output logic [31:0]         res_push_x,
    output logic [31:0]         res_push_y
);
    import bomp_pkg::*;

    localparam logic signed [EXT_W-1:0] EXT_MAX = {1'b0, {(EXT_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] EXT_MIN = {1'b1, {(EXT_W-1){1'b0}}};

    // captured word fields
    logic               mode_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [15:0]        sw_reg, sh_reg, kx_reg, ky_reg;
    logic signed [15:0] rxx_reg, rxy_reg, ryx_reg, ryy_reg;
    logic [HALF_W-1:0]  hw_reg, hh_reg;

    // products of rotation entries with half extents
    logic signed [48:0] pa_x_reg, pb_x_reg, pa_y_reg, pb_y_reg;
    logic signed [EXT_W-1:0] mnx_reg, mxx_reg, mny_reg, mxy_reg;
    logic signed [EXT_W-1:0] cmnx_reg, cmxx_reg, cmny_reg, cmxy_reg;

    // scaled sizes: scale_x*size_w and scale_y*size_h (one product each)
    logic [31:0] hw_prod, hh_prod;
    assign hw_prod = kx_reg * sw_reg;
    assign hh_prod = ky_reg * sh_reg;

    // corner extent for one axis from the two products
    function automatic logic signed [EXT_W-1:0] corner(
        input logic signed [31:0] c,
        input logic signed [48:0] pa,
        input logic signed [48:0] pb,
        input logic sa,
        input logic sb
    );
        logic signed [50:0] s;
        logic signed [50:0] v;
        s = (sa ? 51'(pa) : -51'(pa)) + (sb ? 51'(pb) : -51'(pb));
        v = 51'(c) + (s >>> 14);
        if (v > 51'(EXT_MAX))      return EXT_MAX;
        else if (v < 51'(EXT_MIN)) return EXT_MIN;
        else                       return v[EXT_W-1:0];
    endfunction

    logic signed [EXT_W-1:0] cx [4];
    logic signed [EXT_W-1:0] cy [4];
    logic signed [EXT_W-1:0] lox, hix, loy, hiy;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cx[k] = corner(px_reg, pa_x_reg, pb_x_reg, k[0], k[1]);
            cy[k] = corner(py_reg, pa_y_reg, pb_y_reg, k[0], k[1]);
        end
        lox = cx[0]; hix = cx[0]; loy = cy[0]; hiy = cy[0];
        for (int k = 1; k < 4; k++)
        begin
            if (cx[k] < lox) lox = cx[k];
            if (cx[k] > hix) hix = cx[k];
            if (cy[k] < loy) loy = cy[k];
            if (cy[k] > hiy) hiy = cy[k];
        end
    end

    // overlap test and minimum push
    logic signed [EXT_W:0] pen [4];
    logic [EXT_W:0]        mag [4];
    logic [EXT_W:0]        best;
    logic [1:0]            bi;
    logic                  hit;
    logic signed [EXT_W:0] sel;
    logic signed [31:0]    sat;

    always_comb
    begin
        hit = !(mnx_reg > cmxx_reg || cmnx_reg > mxx_reg) &&
              !(mny_reg > cmxy_reg || cmny_reg > mxy_reg);
        pen[0] = (EXT_W+1)'(mnx_reg) - (EXT_W+1)'(cmxx_reg);
        pen[1] = (EXT_W+1)'(mxx_reg) - (EXT_W+1)'(cmnx_reg);
        pen[2] = (EXT_W+1)'(mny_reg) - (EXT_W+1)'(cmxy_reg);
        pen[3] = (EXT_W+1)'(mxy_reg) - (EXT_W+1)'(cmny_reg);
        for (int i = 0; i < 4; i++)
            mag[i] = pen[i][EXT_W] ? (EXT_W+1)'(-pen[i]) : (EXT_W+1)'(pen[i]);
        best = mag[0];
        bi   = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (mag[i] < best)
            begin
                best = mag[i];
                bi   = 2'(i);
            end
        end
        sel = pen[bi];
        if (sel > 35'sd2147483647)       sat = 32'sh7fffffff;
        else if (sel < -35'sd2147483648) sat = 32'sh80000000;
        else                             sat = sel[31:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            {ryy_reg, ryx_reg, rxy_reg, rxx_reg, ky_reg, kx_reg,
             sh_reg, sw_reg, py_reg, px_reg, mode_reg} <= in_word;
        end
        if (cmd.hx)
        begin
            hw_reg <= hw_prod >> 1;
            hh_reg <= hh_prod >> 1;
        end
        if (cmd.ext)
        begin
            pa_x_reg <= rxx_reg * $signed({1'b0, hw_reg});
            pb_x_reg <= rxy_reg * $signed({1'b0, hh_reg});
            pa_y_reg <= ryx_reg * $signed({1'b0, hw_reg});
            pb_y_reg <= ryy_reg * $signed({1'b0, hh_reg});
        end
        if (cmd.res)
        begin
            mnx_reg <= lox; mxx_reg <= hix;
            mny_reg <= loy; mxy_reg <= hiy;
        end
    end

    // character box state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmnx_reg <= '0; cmxx_reg <= '0; cmny_reg <= '0; cmxy_reg <= '0;
        end
        else if (cmd.res && !mode_reg)
        begin
            cmnx_reg <= lox; cmxx_reg <= hix;
            cmny_reg <= loy; cmxy_reg <= hiy;
        end
    end

    assign res_colliding = hit;
    assign res_push_x    = (hit && !bi[1]) ? sat : 32'd0;
    assign res_push_y    = (hit &&  bi[1]) ? sat : 32'd0;

endmodule

// ----- design/box_overlap_min_push_2d_unit.sv -----
// top level of the box overlap minimum push unit
// depends on bomp_pkg, bomp_ctrl, bomp_datapath
//
// channel | dir | contents
// s_axis  | in  | box word: mode, pos, size, scale, rotation
// m_axis  | out | result word: colliding, push_x, push_y
//
// an item passes capture, half extents, corner products, then extents and
// test; a mode 0 item only stores the box and gives no result.
// a result waits in the output register; the next word is accepted while
// it waits, stalling only before a second result. reset clears the stored
// box to a point at the origin.
module box_overlap_min_push_2d_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode, pos_x, pos_y, size_w, size_h, scale_x, scale_y,
    // rot_xx, rot_xy, rot_yx, rot_yy, 7 zero bits
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // colliding, push_x, push_y, 7 zero bits
    output logic [71:0]  m_axis_tdata
);
    import bomp_pkg::*;

    bomp_cmd_t   cmd;
    logic        out_set;
    logic        res_colliding;
    logic [31:0] res_push_x, res_push_y;
    logic        ovalid_reg;
    logic [64:0] odata_reg;

    bomp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .mode     (s_axis_tdata[0]),
        .out_busy (ovalid_reg && !m_axis_tready),
        .out_set  (out_set),
        .cmd      (cmd)
    );

    bomp_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_word       (s_axis_tdata[192:0]),
        .res_colliding (res_colliding),
        .res_push_x    (res_push_x),
        .res_push_y    (res_push_y)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (out_set)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_set)
            odata_reg <= {res_push_y, res_push_x, res_colliding};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, odata_reg};

endmodule
